FILE: rtl/greedy_interval_assigner_k_servers_top_assert.svh
// Assertion macros for the gia_checker file.
// GIA_ASSERT    : checked only while out of reset.
// GIA_ASSERT_RST: checked on every edge, reset included.
`ifndef GREEDY_INTERVAL_ASSIGNER_K_SERVERS_TOP_ASSERT_SVH
`define GREEDY_INTERVAL_ASSIGNER_K_SERVERS_TOP_ASSERT_SVH

`define GIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define GIA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/gia_pkg.sv
// ----------------------------------------------------------------------------
// gia_pkg
// Types and constants for the greedy interval assigner (k servers).
// ----------------------------------------------------------------------------
package gia_pkg;

  localparam int TIME_WIDTH      = 32;
  localparam int COUNT_WIDTH     = 20;
  localparam int CFG_WIDTH       = 5;
  localparam int MAX_SERVERS_DEF = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic                  new_set;
    logic [TIME_WIDTH-1:0] start_time;
    logic [TIME_WIDTH-1:0] end_time;
  } in_t;

  typedef struct packed {
    logic                   accepted;
    logic [COUNT_WIDTH-1:0] accepted_count;
  } out_t;

endpackage

FILE: rtl/gia_ram.sv
// ----------------------------------------------------------------------------
// gia_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/greedy_interval_assigner_k_servers_top.sv
// An input beat steps through the states SCAN, LAST, UPD and DONE, and the
// result is then registered; one interval is taken at a time, and the server scan
// reads the free-time RAM one entry per cycle through its single read port.
// Reset: synchronous, active low; all free times read as zero, count zero,
// servers_in_use = 1. new_set clears the free times and count at once, no sweep.
// ----------------------------------------------------------------------------
// greedy_interval_assigner_k_servers_top
// Assigns sorted intervals to the server with the latest free time not past
// the start; free times live in a RAM, scanned and updated per interval.
// ----------------------------------------------------------------------------
module greedy_interval_assigner_k_servers_top
  import gia_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW_S  = $clog2(MAX_SERVERS + 1);
  localparam int NW    = (NW_S > CFG_WIDTH) ? NW_S : CFG_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CFG_WIDTH-1:0]   cfg_r;
  logic [MAX_SERVERS-1:0] valid_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [IDX_W-1:0]       rd_idx_r, last_idx_r, cmp_idx_r, best_idx_r;
  logic                   cmp_vld_r, found_r;
  logic [TIME_WIDTH-1:0]  start_r, end_r, best_val_r;
  logic                   out_valid_r;
  out_t                   out_data_r;

  logic [NW-1:0]          n_ext, n_eff;
  logic [IDX_W-1:0]       last_idx;
  logic [TIME_WIDTH-1:0]  rd_data, cmp_val;
  logic                   cand;
  logic                   in_fire, out_free;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // zero acts as one, anything past the server count clamps to it
  always_comb begin
    n_ext = NW'(cfg_r);
    n_eff = n_ext;
    if (n_ext == '0) begin
      n_eff = NW'(1);
    end else if (n_ext > NW'(MAX_SERVERS)) begin
      n_eff = NW'(MAX_SERVERS);
    end
  end
  assign last_idx = IDX_W'(n_eff - NW'(1));

  gia_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (MAX_SERVERS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (state_r == S_UPD && found_r),
    .wr_addr (best_idx_r),
    .wr_data (end_r),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // never-written entries read as zero
  assign cmp_val = valid_r[cmp_idx_r] ? rd_data : '0;
  assign cand    = cmp_vld_r && (cmp_val <= start_r) &&
                   (!found_r || (cmp_val > best_val_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SCAN;
      S_SCAN: if (rd_idx_r == last_idx_r) state_nxt = S_LAST;
      S_LAST: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_WIDTH'(1);
      valid_r     <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (in_fire) begin
        found_r <= 1'b0;
        if (in_data.new_set) begin
          valid_r <= '0;
          count_r <= '0;
        end
      end else if (cand) begin
        found_r <= 1'b1;
      end
      if (state_r == S_UPD && found_r) begin
        valid_r[best_idx_r] <= 1'b1;
        if (count_r != COUNT_MAX) begin
          count_r <= count_r + COUNT_WIDTH'(1);
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_r    <= in_data.start_time;
      end_r      <= in_data.end_time;
      last_idx_r <= last_idx;
      rd_idx_r   <= '0;
    end else if (state_r == S_SCAN && rd_idx_r != last_idx_r) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    cmp_idx_r <= rd_idx_r;
    if (cand) begin
      best_idx_r <= cmp_idx_r;
      best_val_r <= cmp_val;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.accepted       <= found_r;
      out_data_r.accepted_count <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/gia_checker.sv
// ----------------------------------------------------------------------------
// gia_checker
// Port-level checks for the greedy interval assigner, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_interval_assigner_k_servers_top_assert.svh"

module gia_checker
  import gia_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_t                 out_data
);

  // stalled result beat holds
  `GIA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result beat changed under stall")

  `GIA_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid out of reset")

  // one interval at a time: busy right after a beat is taken
  `GIA_ASSERT(a_busy, in_valid && !in_stall |=> in_stall, "input taken while busy")

  // a new result only follows a busy period
  `GIA_ASSERT(a_res_after_busy, $rose(out_valid) |-> $past(in_stall), "result without work")

endmodule

bind greedy_interval_assigner_k_servers_top gia_checker u_gia_checker (.*);

FILE: tb/sv/tb_greedy_interval_assigner_k_servers_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_interval_assigner_k_servers_top
// Self-checking bench for the k-server greedy interval assigner. A scoreboard
// model tracks per-server free times and the set count. Every accepted input
// beat queues its expected result, and each output beat is checked in order.
// Stimulus: directed corner cases, then mostly sorted interval sets with
// random content and some noise, under random and sustained backpressure.
// ----------------------------------------------------------------------------
module tb_greedy_interval_assigner_k_servers_top;
  import gia_pkg::*;

  localparam int NUM_SRV = MAX_SERVERS_DEF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  // scoreboard model state
  logic [TIME_WIDTH-1:0]  srv_free [NUM_SRV];
  logic [COUNT_WIDTH-1:0] set_count = '0;
  logic [CFG_WIDTH-1:0]   srv_in_use = 5'd1;

  out_t pending_results[$];
  out_t want_res;
  int   errors = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;

  // long receiver hold-off, requested by bumping hold_req
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  greedy_interval_assigner_k_servers_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_SRV; i++) srv_free[i] = '0;
  end

  function automatic void log_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // greedy pick: latest free time not past the start, lowest index on ties
  function automatic out_t assign_interval(in_t it);
    int   n;
    int   best;
    bit   found;
    out_t r;
    if (it.new_set) begin
      for (int i = 0; i < NUM_SRV; i++) srv_free[i] = '0;
      set_count = '0;
    end
    n = int'(srv_in_use);
    if (n < 1) n = 1;
    if (n > NUM_SRV) n = NUM_SRV;
    found = 1'b0;
    best = 0;
    for (int i = 0; i < n; i++) begin
      if (srv_free[i] <= it.start_time) begin
        if (!found || srv_free[i] > srv_free[best]) begin
          best = i;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      srv_free[best] = it.end_time;
      if (set_count != COUNT_MAX) set_count = set_count + COUNT_WIDTH'(1);
    end
    r.accepted = found;
    r.accepted_count = set_count;
    return r;
  endfunction

  function automatic in_t mk(bit ns, logic [TIME_WIDTH-1:0] s, logic [TIME_WIDTH-1:0] e);
    in_t it;
    it.new_set = ns;
    it.start_time = s;
    it.end_time = e;
    return it;
  endfunction

  // output check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_error($sformatf("unexpected result beat acc=%0b cnt=%0d",
                            out_data.accepted, out_data.accepted_count));
      end else begin
        want_res = pending_results.pop_front();
        if (out_data.accepted !== want_res.accepted)
          log_error($sformatf("accepted: exp %0b got %0b",
                              want_res.accepted, out_data.accepted));
        if (out_data.accepted_count !== want_res.accepted_count)
          log_error($sformatf("accepted_count: exp %0d got %0d",
                              want_res.accepted_count, out_data.accepted_count));
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rcv_idle);
    end
  end

  task automatic send_interval(in_t it);
    while ($urandom_range(99, 0) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results = {pending_results, assign_interval(it)};
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_servers(logic [CFG_WIDTH-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    srv_in_use = v;
  endtask

  // intervals sorted by end, ties by start; fresh starts a new set
  task automatic send_sorted_set(int m, bit fresh);
    logic [TIME_WIDTH-1:0] t_end;
    logic [TIME_WIDTH-1:0] t_start;
    logic [TIME_WIDTH-1:0] prev_start;
    logic [TIME_WIDTH-1:0] step;
    logic [TIME_WIDTH-1:0] len;
    int sh;
    int lsh;
    t_end = $urandom_range(32'hFF00_0000, 0);
    sh = $urandom_range(19, 0);
    lsh = $urandom_range(22, 0);
    prev_start = '0;
    for (int k = 0; k < m; k++) begin
      step = ($urandom_range(3, 0) == 0) ? '0 : $urandom_range(1 << sh, 0);
      t_end = t_end + step;
      if (k > 0 && step == 0) begin
        t_start = prev_start + $urandom_range(t_end - prev_start, 0);
      end else begin
        len = $urandom_range(1 << lsh, 0);
        t_start = (len > t_end) ? '0 : t_end - len;
      end
      prev_start = t_start;
      send_interval(mk(fresh && (k == 0), t_start, t_end));
    end
  endtask

  task automatic send_noise_item();
    logic [TIME_WIDTH-1:0] s;
    logic [TIME_WIDTH-1:0] e;
    s = $urandom;
    e = $urandom;
    case ($urandom_range(3, 0))
      0: ;
      1: e = s - $urandom_range(1000, 1);  // end before start
      2: s = '1;
      default: begin
        s = '0;
        e = '1;
      end
    endcase
    send_interval(mk($urandom_range(7, 0) == 0, s, e));
  endtask

  task automatic test_directed();
    snd_idle = 31;
    rcv_idle = 88;
    // one server after reset, time extremes
    send_interval(mk(1'b1, '0, '0));
    send_interval(mk(1'b0, '0, '1));
    send_interval(mk(1'b0, '1, '1));
    send_interval(mk(1'b0, 32'd5, 32'd6));
    // zero servers behaves as one
    wait_idle();
    write_servers(5'd0);
    send_interval(mk(1'b1, 32'd10, 32'd20));
    send_interval(mk(1'b0, 32'd15, 32'd25));
    // oversized server count clamps to the maximum
    wait_idle();
    write_servers(5'd31);
    for (int k = 0; k <= NUM_SRV; k++) send_interval(mk(k == 0, 32'd100, 32'd200));
    // end before start, then a write in mid-set and equal free times
    wait_idle();
    write_servers(5'd2);
    send_interval(mk(1'b1, 32'd50, 32'd40));
    send_interval(mk(1'b0, 32'd50, 32'd60));
    wait_idle();
    write_servers(5'd16);
    send_interval(mk(1'b0, 32'd30, 32'd30));
    send_interval(mk(1'b0, 32'd30, 32'd35));
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int n_items);
    int sent;
    int pick;
    int m;
    snd_idle = snd_pct;
    rcv_idle = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        wait_idle();
        case ($urandom_range(9, 0))
          0:       write_servers(5'd0);
          1:       write_servers(5'd31);
          2:       write_servers(5'd16);
          3:       write_servers(5'd1);
          default: write_servers(CFG_WIDTH'($urandom_range(31, 0)));
        endcase
      end
      if (pick < 80) begin
        m = $urandom_range(24, 1);
        // low picks keep the old set across the register write
        send_sorted_set(m, pick >= 3);
        sent += m;
      end else begin
        send_noise_item();
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    wait_idle();
    write_servers(5'd8);
    hold_req <= hold_req + 1;
    send_sorted_set(20, 1'b1);
    send_sorted_set(20, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(31, 88, 630);
    test_backpressure();
    test_random(88, 31, 630);
    test_random(0, 0, 630);
    wait_idle();
    repeat (30) @(posedge clk);
    if (pending_results.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
